FILE: rtl/spm_pkg.sv
package spm_pkg;

    localparam int JW               = 15;
    localparam int BIN_W            = 32;
    localparam int DIM_W            = 13;
    localparam int HALF_W           = 15;
    localparam int Z_W              = 16;
    localparam int GAIN_W           = 16;
    localparam int ANG_W            = 34;
    localparam int HUE_FRAC         = 31;
    localparam int HUE_STEPS        = JW + HUE_FRAC;
    localparam int ROW_W            = JW + DIM_W;
    localparam int SQRT_STEPS       = 32;
    localparam int Q_DEPTH          = 4;
    localparam int IN_W             = 144;
    localparam int OUT_W            = 72;
    localparam int PIX_W            = 12;
    localparam int COL_W            = 16;

    localparam int MAX_BINS         = 16384;
    localparam int MAX_DIMENSION    = 4096;
    localparam int CORDIC_STEPS_DEF = 16;

    // angles: pi = 2^30
    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd536870912;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 34'sd2147483648;
    localparam logic signed [ANG_W-1:0] INV_GAIN    = 34'sd652032874;

    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_HALF   = 2'd3;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [32] = '{
        34'sd268435456, 34'sd158466703, 34'sd83729454, 34'sd42502378,
        34'sd21333666, 34'sd10677233, 34'sd5339919, 34'sd2670123,
        34'sd1335082, 34'sd667543, 34'sd333772, 34'sd166886,
        34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430,
        34'sd5215, 34'sd2608, 34'sd1304, 34'sd652,
        34'sd326, 34'sd163, 34'sd81, 34'sd41,
        34'sd20, 34'sd10, 34'sd5, 34'sd3,
        34'sd1, 34'sd1, 34'sd0, 34'sd0
    };

    // products of one bin pair, handed from front to back
    typedef struct packed {
        logic [JW-1:0]        step;
        logic signed [63:0]   p_rl;
        logic signed [63:0]   p_ii;
        logic signed [63:0]   p_lr;
        logic signed [63:0]   p_ir;
        logic [63:0]          sq_lre;
        logic [63:0]          sq_lim;
        logic [63:0]          sq_rre;
        logic [63:0]          sq_rim;
    } spm_prod_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [DIM_W-1:0]  w1;
        logic [DIM_W-1:0]  h;
        logic [Z_W-1:0]    z;
    } spm_cfg_t;

endpackage

FILE: rtl/spm_front.sv
module spm_front
    import spm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,
    input  logic            q_full,
    output logic            q_push,
    output spm_prod_t       q_wdata
);

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [IN_W-2:0]         in_data_reg;
    logic                    accept;
    logic signed [BIN_W-1:0] lre;
    logic signed [BIN_W-1:0] lim;
    logic signed [BIN_W-1:0] rre;
    logic signed [BIN_W-1:0] rim;
    logic [BIN_W-1:0]        a_lre;
    logic [BIN_W-1:0]        a_lim;
    logic [BIN_W-1:0]        a_rre;
    logic [BIN_W-1:0]        a_rim;

    assign s_axis_tready = !in_valid_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_push        = in_valid_reg && !q_full;
    assign in_valid_next = accept || (in_valid_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= s_axis_tdata[IN_W-2:0];
        end
    end

    assign lre = $signed(in_data_reg[JW +: BIN_W]);
    assign lim = $signed(in_data_reg[JW + BIN_W +: BIN_W]);
    assign rre = $signed(in_data_reg[JW + 2*BIN_W +: BIN_W]);
    assign rim = $signed(in_data_reg[JW + 3*BIN_W +: BIN_W]);

    // magnitude of -2^31 is still right as an unsigned 32-bit pattern
    assign a_lre = lre[BIN_W-1] ? BIN_W'(-lre) : lre;
    assign a_lim = lim[BIN_W-1] ? BIN_W'(-lim) : lim;
    assign a_rre = rre[BIN_W-1] ? BIN_W'(-rre) : rre;
    assign a_rim = rim[BIN_W-1] ? BIN_W'(-rim) : rim;

    always_comb
    begin
        q_wdata.step   = in_data_reg[JW-1:0];
        q_wdata.p_rl   = 64'(rre) * 64'(lre);
        q_wdata.p_ii   = 64'(rim) * 64'(lim);
        q_wdata.p_lr   = 64'(lre) * 64'(rim);
        q_wdata.p_ir   = 64'(lim) * 64'(rre);
        q_wdata.sq_lre = 64'(a_lre) * 64'(a_lre);
        q_wdata.sq_lim = 64'(a_lim) * 64'(a_lim);
        q_wdata.sq_rre = 64'(a_rre) * 64'(a_rre);
        q_wdata.sq_rim = 64'(a_rim) * 64'(a_rim);
    end

endmodule

FILE: rtl/spm_queue.sv
module spm_queue
    import spm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  spm_prod_t wdata,
    input  logic      pop,
    output logic      full,
    output logic      avail,
    output spm_prod_t head
);

    localparam int QP_W = $clog2(Q_DEPTH);

    spm_prod_t       mem_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W:0]   cnt_reg;
    logic [QP_W:0]   cnt_next;

    assign full  = (cnt_reg == (QP_W+1)'(Q_DEPTH));
    assign avail = (cnt_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/spm_back.sv
module spm_back
    import spm_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  spm_cfg_t         cfg,
    input  logic             q_avail,
    input  spm_prod_t        q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    localparam int ST_COL  = CORDIC_STEPS + 3;
    localparam int ST_YB   = SQRT_STEPS + 3;
    localparam int ST_ROW  = ROW_W + 1;
    localparam int ST_MIX  = HUE_STEPS + CORDIC_STEPS + 3;
    localparam int LAST    = ST_MIX + 1;
    localparam int COL_DLY = ST_MIX - ST_COL;
    localparam int ROW_DLY = ST_MIX - ST_ROW;
    localparam int YB_DLY  = ST_MIX - 1 - ST_YB;

    function automatic logic [127:0] sqrt_step(input logic [63:0] rem,
                                               input logic [63:0] root,
                                               input int k);
        logic [63:0] bitv;
        logic [63:0] trial;
        bitv  = 64'd1 << (62 - 2*k);
        trial = root + bitv;
        if (rem >= trial)
            return {rem - trial, (root >> 1) + bitv};
        else
            return {rem, root >> 1};
    endfunction

    // returns {quotient bit, new remainder}
    function automatic logic [Z_W:0] div_step(input logic [Z_W-1:0] rem,
                                              input logic din,
                                              input logic [Z_W-1:0] z);
        logic [Z_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, z})
            return {1'b1, Z_W'(t - {1'b0, z})};
        else
            return {1'b0, t[Z_W-1:0]};
    endfunction

    function automatic logic [COL_W-1:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'h7fff;
        else if (v < -20'sd32768)
            return 16'h8000;
        else
            return v[COL_W-1:0];
    endfunction

    logic                    adv;
    logic [LAST:0]           vld_reg;

    // vectoring CORDIC (phase)
    logic signed [63:0]      at_x_reg [CORDIC_STEPS+1];
    logic signed [63:0]      at_y_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] at_a_reg [CORDIC_STEPS+1];
    logic                    at_z_reg [CORDIC_STEPS+1];
    logic signed [63:0]      cre_reg;
    logic signed [63:0]      cim_reg;
    logic signed [63:0]      cre_next;
    logic signed [63:0]      cim_next;
    logic [31:0]             diff_reg;
    logic signed [ANG_W-1:0] clip_a;
    logic [44:0]             col_prod;
    logic [DIM_W-1:0]        col_reg;
    logic [DIM_W-1:0]        col_dly_reg [COL_DLY];

    // magnitudes and brightness
    logic [63:0]             sl_rem_reg  [SQRT_STEPS+1];
    logic [63:0]             sl_root_reg [SQRT_STEPS+1];
    logic [63:0]             sr_rem_reg  [SQRT_STEPS+1];
    logic [63:0]             sr_root_reg [SQRT_STEPS+1];
    logic [33:0]             msum_reg;
    logic [35:0]             ybw_reg;
    logic [49:0]             ybw_prod;
    logic [JW-1:0]           yb_reg;
    logic [JW-1:0]           yb_dly_reg [YB_DLY];

    // row divider
    logic [Z_W-1:0]          rw_rem_reg [ROW_W+1];
    logic [ROW_W-1:0]        rw_d_reg   [ROW_W+1];
    logic [ROW_W-1:0]        rw_q_reg   [ROW_W+1];
    logic [DIM_W-1:0]        row_reg;
    logic [DIM_W-1:0]        row_next;
    logic [DIM_W-1:0]        row_dly_reg [ROW_DLY];

    // hue divider and rotation CORDIC
    logic [Z_W-1:0]          hu_rem_reg [HUE_STEPS+1];
    logic [HUE_STEPS-1:0]    hu_d_reg   [HUE_STEPS+1];
    logic [HUE_FRAC-1:0]     hu_q_reg   [HUE_STEPS+1];
    logic signed [ANG_W-1:0] cs_x_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] cs_y_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] cs_a_reg [CORDIC_STEPS+1];
    logic                    cs_n_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] fold_e;
    logic signed [ANG_W-1:0] fold_a;
    logic                    fold_n;
    logic signed [ANG_W-1:0] cos_reg;
    logic signed [ANG_W-1:0] sin_reg;
    logic signed [49:0]      pco;
    logic signed [49:0]      pcg;
    logic signed [17:0]      co_reg;
    logic signed [17:0]      cg_reg;
    logic [JW-1:0]           ybm_reg;

    logic signed [19:0]      mix_y;
    logic signed [19:0]      mix_t;
    logic [COL_W-1:0]        g_out;
    logic [COL_W-1:0]        b_out;
    logic [COL_W-1:0]        r_out;
    logic [OUT_W-1:0]        out_reg;

    assign adv       = !vld_reg[LAST] || out_ready;
    assign q_pop     = adv && q_avail;
    assign out_valid = vld_reg[LAST];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], q_pop};
        end
    end

    assign cre_next = (q_head.p_rl >>> 3) + (q_head.p_ii >>> 3);
    assign cim_next = (q_head.p_lr >>> 3) - (q_head.p_ir >>> 3);

    always_comb
    begin
        clip_a = at_a_reg[CORDIC_STEPS];
        if (at_z_reg[CORDIC_STEPS])
        begin
            clip_a = '0;
        end
        else if (clip_a > ANG_PI)
        begin
            clip_a = ANG_PI;
        end
        else if (clip_a < -ANG_PI)
        begin
            clip_a = -ANG_PI;
        end
    end

    assign col_prod = 45'(cfg.w1) * 45'(diff_reg);
    assign ybw_prod = 50'(msum_reg) * 50'(cfg.gain);

    always_comb
    begin
        if (cfg.h == '0)
        begin
            row_next = '0;
        end
        else if (rw_q_reg[ROW_W] > ROW_W'(cfg.h - 1'b1))
        begin
            row_next = cfg.h - 1'b1;
        end
        else
        begin
            row_next = rw_q_reg[ROW_W][DIM_W-1:0];
        end
    end

    // hue angle into -pi..pi, then folded into -pi/2..pi/2
    always_comb
    begin
        fold_e = $signed({3'b000, hu_q_reg[HUE_STEPS]});
        if (hu_q_reg[HUE_STEPS][HUE_FRAC-1])
        begin
            fold_e = fold_e - ANG_TWO_PI;
        end
        fold_a = fold_e;
        fold_n = 1'b0;
        if (fold_e > ANG_HALF_PI)
        begin
            fold_a = fold_e - ANG_PI;
            fold_n = 1'b1;
        end
        else if (fold_e < -ANG_HALF_PI)
        begin
            fold_a = fold_e + ANG_PI;
            fold_n = 1'b1;
        end
    end

    assign pco = 50'($signed({1'b0, yb_dly_reg[YB_DLY-1]})) * 50'(cos_reg);
    assign pcg = 50'($signed({1'b0, yb_dly_reg[YB_DLY-1]})) * 50'(sin_reg);

    assign mix_y = $signed({5'b00000, ybm_reg});
    assign mix_t = mix_y - 20'(cg_reg);
    assign g_out = sat16(mix_y + 20'(cg_reg));
    assign b_out = sat16(mix_t - 20'(co_reg));
    assign r_out = sat16(mix_t + 20'(co_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // first stage
            cre_reg           <= cre_next;
            cim_reg           <= cim_next;
            sl_rem_reg[0]     <= q_head.sq_lre + q_head.sq_lim;
            sl_root_reg[0]    <= '0;
            sr_rem_reg[0]     <= q_head.sq_rre + q_head.sq_rim;
            sr_root_reg[0]    <= '0;
            rw_rem_reg[0]     <= '0;
            rw_q_reg[0]       <= '0;
            rw_d_reg[0]       <= ROW_W'(q_head.step) * ROW_W'(cfg.h);
            hu_rem_reg[0]     <= '0;
            hu_q_reg[0]       <= '0;
            hu_d_reg[0]       <= {q_head.step, {HUE_FRAC{1'b0}}};

            // phase
            at_z_reg[0] <= (cre_reg == '0) && (cim_reg == '0);
            if (cre_reg < 0)
            begin
                at_x_reg[0] <= -cre_reg;
                at_y_reg[0] <= -cim_reg;
                at_a_reg[0] <= (cim_reg >= 0) ? ANG_PI : -ANG_PI;
            end
            else
            begin
                at_x_reg[0] <= cre_reg;
                at_y_reg[0] <= cim_reg;
                at_a_reg[0] <= '0;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                at_z_reg[i+1] <= at_z_reg[i];
                if (at_y_reg[i] > 0)
                begin
                    at_x_reg[i+1] <= at_x_reg[i] + (at_y_reg[i] >>> i);
                    at_y_reg[i+1] <= at_y_reg[i] - (at_x_reg[i] >>> i);
                    at_a_reg[i+1] <= at_a_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    at_x_reg[i+1] <= at_x_reg[i] - (at_y_reg[i] >>> i);
                    at_y_reg[i+1] <= at_y_reg[i] + (at_x_reg[i] >>> i);
                    at_a_reg[i+1] <= at_a_reg[i] - ATAN_TAB[i];
                end
            end
            diff_reg       <= 32'(ANG_PI - clip_a);
            col_reg        <= col_prod[43:31];
            col_dly_reg[0] <= col_reg;
            for (int k = 1; k < COL_DLY; k++)
            begin
                col_dly_reg[k] <= col_dly_reg[k-1];
            end

            // magnitudes
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                {sl_rem_reg[k+1], sl_root_reg[k+1]} <=
                    sqrt_step(sl_rem_reg[k], sl_root_reg[k], k);
                {sr_rem_reg[k+1], sr_root_reg[k+1]} <=
                    sqrt_step(sr_rem_reg[k], sr_root_reg[k], k);
            end
            msum_reg <= 34'(sl_root_reg[SQRT_STEPS]) + 34'(sr_root_reg[SQRT_STEPS]);
            ybw_reg  <= ybw_prod[49:14];
            yb_reg   <= (ybw_reg > 36'd16384) ? JW'(16384) : ybw_reg[JW-1:0];
            yb_dly_reg[0] <= yb_reg;
            for (int k = 1; k < YB_DLY; k++)
            begin
                yb_dly_reg[k] <= yb_dly_reg[k-1];
            end

            // row
            for (int k = 0; k < ROW_W; k++)
            begin
                {rw_q_reg[k+1][0], rw_rem_reg[k+1]} <=
                    div_step(rw_rem_reg[k], rw_d_reg[k][ROW_W-1], cfg.z);
                rw_q_reg[k+1][ROW_W-1:1] <= rw_q_reg[k][ROW_W-2:0];
                rw_d_reg[k+1]            <= rw_d_reg[k] << 1;
            end
            row_reg        <= row_next;
            row_dly_reg[0] <= row_reg;
            for (int k = 1; k < ROW_DLY; k++)
            begin
                row_dly_reg[k] <= row_dly_reg[k-1];
            end

            // hue: only the fraction of j*2^31/z is kept
            for (int k = 0; k < HUE_STEPS; k++)
            begin
                {hu_q_reg[k+1][0], hu_rem_reg[k+1]} <=
                    div_step(hu_rem_reg[k], hu_d_reg[k][HUE_STEPS-1], cfg.z);
                hu_q_reg[k+1][HUE_FRAC-1:1] <= hu_q_reg[k][HUE_FRAC-2:0];
                hu_d_reg[k+1]               <= hu_d_reg[k] << 1;
            end
            cs_x_reg[0] <= INV_GAIN;
            cs_y_reg[0] <= '0;
            cs_a_reg[0] <= fold_a;
            cs_n_reg[0] <= fold_n;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                cs_n_reg[i+1] <= cs_n_reg[i];
                if (cs_a_reg[i] >= 0)
                begin
                    cs_x_reg[i+1] <= cs_x_reg[i] - (cs_y_reg[i] >>> i);
                    cs_y_reg[i+1] <= cs_y_reg[i] + (cs_x_reg[i] >>> i);
                    cs_a_reg[i+1] <= cs_a_reg[i] - ATAN_TAB[i];
                end
                else
                begin
                    cs_x_reg[i+1] <= cs_x_reg[i] + (cs_y_reg[i] >>> i);
                    cs_y_reg[i+1] <= cs_y_reg[i] - (cs_x_reg[i] >>> i);
                    cs_a_reg[i+1] <= cs_a_reg[i] + ATAN_TAB[i];
                end
            end
            cos_reg <= cs_n_reg[CORDIC_STEPS] ? -cs_x_reg[CORDIC_STEPS]
                                              : cs_x_reg[CORDIC_STEPS];
            sin_reg <= cs_n_reg[CORDIC_STEPS] ? -cs_y_reg[CORDIC_STEPS]
                                              : cs_y_reg[CORDIC_STEPS];
            co_reg  <= pco[48:31];
            cg_reg  <= pcg[48:31];
            ybm_reg <= yb_dly_reg[YB_DLY-1];

            out_reg <= {r_out, b_out, g_out,
                        row_dly_reg[ROW_DLY-1][PIX_W-1:0],
                        col_dly_reg[COL_DLY-1][PIX_W-1:0]};
        end
    end

endmodule

FILE: rtl/stereo_phase_scope_pixel_mapper.sv
// Stereo phase scope pixel mapper.
// Input stream: one left/right spectrum bin pair plus draw step per request,
// taken on s_axis_tvalid & s_axis_tready. Output stream: column, row and
// green/blue/red increments, one request per input request, same order.
// The APB port holds contrast gain, picture width, picture height and
// transform half size; write them only while no request is in flight.
// The path from input handshake to output valid is set by the 46-step
// hue divider and the rotation CORDIC that follows it. Throughput is one
// request per cycle while m_axis_tready is not held low.
// The input stage multiplies the bins and feeds a 4-entry queue; the back
// pipeline advances as a whole while its output register is empty or taken.
// When the receiver holds m_axis_tready low the back pipeline halts, the
// queue fills and s_axis_tready drops; nothing is lost.
// Reset empties the pipeline and queue and loads the register defaults
// (gain 0.25, 800 x 600, half size 2048).
module stereo_phase_scope_pixel_mapper
    import spm_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // loop_step, left_real, left_imag, right_real, right_imag, 1 pad bit
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // pixel_column, pixel_row, green_add, blue_add, red_add
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [GAIN_W-1:0] gain_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [HALF_W-1:0] half_reg;
    logic              wr_en;
    logic [DIM_W-1:0]  w_clamp;
    logic [DIM_W-1:0]  h_clamp;
    logic [HALF_W-1:0] half_clamp;
    spm_cfg_t          cfg;

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_avail;
    spm_prod_t         q_wdata;
    spm_prod_t         q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_W'(4096);
            width_reg  <= DIM_W'(800);
            height_reg <= DIM_W'(600);
            half_reg   <= HALF_W'(2048);
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_GAIN:   gain_reg   <= pwdata[GAIN_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_HALF:   half_reg   <= pwdata[HALF_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GAIN:   prdata = 32'(gain_reg);
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_HALF:   prdata = 32'(half_reg);
            default:    prdata = '0;
        endcase
    end

    assign w_clamp    = (width_reg > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : width_reg;
    assign h_clamp    = (height_reg > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : height_reg;
    assign half_clamp = (half_reg > MAX_BINS) ? HALF_W'(MAX_BINS) : half_reg;

    always_comb
    begin
        cfg.gain = gain_reg;
        cfg.w1   = (w_clamp != '0) ? w_clamp - 1'b1 : '0;
        cfg.h    = h_clamp;
        cfg.z    = Z_W'(half_clamp) + 1'b1;
    end

    spm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    spm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .full  (q_full),
        .avail (q_avail),
        .head  (q_head)
    );

    spm_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_avail   (q_avail),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import spm_pkg::*;

    localparam longint PI_Q      = 64'sd1073741824;
    localparam longint HUE_GAIN  = 64'sd652032874;
    localparam int     ROT_STEPS = 16;
    localparam int     SETTLE    = 120;
    localparam int     STALL_MAX = 6000;

    typedef struct {
        logic [JW-1:0]           step;
        logic signed [BIN_W-1:0] lre;
        logic signed [BIN_W-1:0] lim;
        logic signed [BIN_W-1:0] rre;
        logic signed [BIN_W-1:0] rim;
    } bin_pair_t;

    typedef struct {
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        logic signed [15:0] green;
        logic signed [15:0] blue;
        logic signed [15:0] red;
    } pixel_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    stereo_phase_scope_pixel_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    longint atan_steps [32] = '{
        268435456, 158466703, 83729454, 42502378, 21333666, 10677233, 5339919,
        2670123, 1335082, 667543, 333772, 166886, 83443, 41722, 20861, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0
    };

    // register copies, updated on the APB write edge
    longint unsigned gain_q, width_q, height_q, half_q;

    bin_pair_t bin_queue [$];
    pixel_t    pixel_queue [$];
    bin_pair_t cur_pair;
    int        send_gap;
    int        take_gap;
    bit        no_idle;
    bit        in_fire;
    bit        out_fire;
    int        errors;
    int        pairs_sent;
    int        pixels_checked;
    int        settings_run;
    int        quiet_cycles;

    function automatic longint phase_of(longint cy, longint cx);
        longint a;
        longint dx;
        longint dy;
        a = 0;
        if (cx == 0 && cy == 0)
            return 0;
        if (cx < 0)
        begin
            a  = (cy >= 0) ? PI_Q : -PI_Q;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0)
            begin
                cx += dx; cy -= dy; a += atan_steps[i];
            end
            else
            begin
                cx -= dx; cy += dy; a -= atan_steps[i];
            end
        end
        if (a > PI_Q)
            a = PI_Q;
        if (a < -PI_Q)
            a = -PI_Q;
        return a;
    endfunction

    function automatic void hue_rotate(longint a, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        x = HUE_GAIN;
        y = 0;
        flip = 0;
        if (a > PI_Q / 2)
        begin
            a -= PI_Q; flip = 1;
        end
        else if (a < -PI_Q / 2)
        begin
            a += PI_Q; flip = 1;
        end
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0)
            begin
                x -= dx; y += dy; a -= atan_steps[i];
            end
            else
            begin
                x += dx; y -= dy; a += atan_steps[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned bin_mag(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        return root_of(ua * ua + ub * ub);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic pixel_t map_pixel(bin_pair_t p);
        pixel_t          px;
        longint unsigned j, w, h, hs, z, w1, col, row, sum, yb, hue_u;
        longint          lre, lim, rre, rim, cre, cim, ph, cv, sv, co, cg, t, e;
        j   = p.step;
        lre = p.lre; lim = p.lim; rre = p.rre; rim = p.rim;
        w   = (width_q > MAX_DIMENSION) ? MAX_DIMENSION : width_q;
        h   = (height_q > MAX_DIMENSION) ? MAX_DIMENSION : height_q;
        hs  = (half_q > MAX_BINS) ? MAX_BINS : half_q;
        z   = hs + 1;
        w1  = (w > 0) ? w - 1 : 0;
        cre = ((rre * lre) >>> 3) + ((rim * lim) >>> 3);
        cim = ((lre * rim) >>> 3) - ((lim * rre) >>> 3);
        ph  = phase_of(cim, cre);
        col = (w1 * longint'(PI_Q - ph)) >> 31;
        if (h == 0)
            row = 0;
        else
        begin
            row = j * h / z;
            if (row > h - 1)
                row = h - 1;
        end
        sum = bin_mag(lre, lim) + bin_mag(rre, rim);
        yb  = (sum * gain_q) >> 14;
        if (yb > 16384)
            yb = 16384;
        // hue angle wraps once per 2*pi
        hue_u = ((j << 31) / z) & ((64'd1 << 31) - 1);
        e = hue_u;
        if (e >= PI_Q)
            e -= 2 * PI_Q;
        hue_rotate(e, cv, sv);
        co = (longint'(yb) * cv) >>> 31;
        cg = (longint'(yb) * sv) >>> 31;
        t  = longint'(yb) - cg;
        px.col   = col[PIX_W-1:0];
        px.row   = row[PIX_W-1:0];
        px.green = clip16(longint'(yb) + cg);
        px.blue  = clip16(t - co);
        px.red   = clip16(t + co);
        return px;
    endfunction

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // sender
    always @(posedge clk)
    begin
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pixel_queue.push_back(map_pixel(cur_pair));
            pairs_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
                send_gap = draw_gap();
            if (s_axis_tvalid && !in_fire)
                ;
            else if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end
            else if (bin_queue.size() > 0)
            begin
                cur_pair = bin_queue.pop_front();
                s_axis_tdata <= {1'b0, cur_pair.rim, cur_pair.rre, cur_pair.lim,
                                 cur_pair.lre, cur_pair.step};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        pixel_t want;
        out_fire <= m_axis_tvalid && m_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_queue.size() == 0)
            begin
                $error("unexpected pixel request %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pixel_queue.pop_front();
                pixels_checked++;
                if (m_axis_tdata[11:0] !== want.col)
                begin
                    $error("pixel_column expected %0d got %0d", want.col, m_axis_tdata[11:0]);
                    errors++;
                end
                if (m_axis_tdata[23:12] !== want.row)
                begin
                    $error("pixel_row expected %0d got %0d", want.row, m_axis_tdata[23:12]);
                    errors++;
                end
                if (m_axis_tdata[39:24] !== want.green)
                begin
                    $error("green_add expected %0d got %0d", want.green,
                           $signed(m_axis_tdata[39:24]));
                    errors++;
                end
                if (m_axis_tdata[55:40] !== want.blue)
                begin
                    $error("blue_add expected %0d got %0d", want.blue,
                           $signed(m_axis_tdata[55:40]));
                    errors++;
                end
                if (m_axis_tdata[71:56] !== want.red)
                begin
                    $error("red_add expected %0d got %0d", want.red,
                           $signed(m_axis_tdata[71:56]));
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                take_gap = draw_gap();
            if (take_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                take_gap--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // watchdog: cycles with work pending but no handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (bin_queue.size() == 0 && pixel_queue.size() == 0 && !s_axis_tvalid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("watchdog expired with %0d pixels outstanding", pixel_queue.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_GAIN:   gain_q   = val[15:0];
            REG_WIDTH:  width_q  = val[12:0];
            REG_HEIGHT: height_q = val[12:0];
            REG_HALF:   half_q   = val[14:0];
            default:    ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_pair(int j, int a, int b, int c, int d);
        bin_pair_t p;
        p.step = j[14:0];
        p.lre = a; p.lim = b; p.rre = c; p.rim = d;
        bin_queue.push_back(p);
    endtask

    function automatic int rand_bin();
        int v;
        v = $urandom();
        // mostly modest amplitudes so brightness does not always clip
        if ($urandom_range(0, 3) != 0)
            v = v >>> $urandom_range(4, 31);
        return v;
    endfunction

    task automatic add_random(int n);
        int j;
        longint unsigned z;
        z = ((half_q > MAX_BINS) ? MAX_BINS : half_q) + 1;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                j = $urandom_range(0, 32767);
            else
                j = $urandom_range(0, (z + 2 > 32767) ? 32767 : int'(z + 2));
            add_pair(j, rand_bin(), rand_bin(), rand_bin(), rand_bin());
        end
    endtask

    task automatic drain();
        while (bin_queue.size() > 0 || pixel_queue.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_setting(int g, int w, int h, int hs, int n);
        reg_write(REG_GAIN, g);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_HALF, hs);
        settings_run++;
        no_idle = ($urandom_range(0, 3) == 0);
        add_random(n);
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        gain_q = 4096; width_q = 800; height_q = 600; half_q = 2048;
        send_gap = 0; take_gap = 0; no_idle = 0;
        errors = 0; pairs_sent = 0; pixels_checked = 0; settings_run = 1;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, at reset values
        add_pair(0, 0, 0, 0, 0);                           // zero cross spectrum
        add_pair(1, 65536, 0, -65536, 0);                  // negative real axis, im = 0
        add_pair(2, 65536, 100, -65536, 0);                // near -real, im above zero
        add_pair(3, 65536, -100, -65536, 0);               // near -real, im below zero
        add_pair(4, 65536, 0, 0, 65536);                   // +pi/2
        add_pair(5, 65536, 0, 0, -65536);                  // -pi/2
        add_pair(2048, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_pair(2049, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        add_pair(2050, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        add_pair(16384, 1000, -2000, 3000, 4000);
        add_pair(32767, -4096, 8192, 12, -7);              // step beyond bins, hue wraps
        add_pair(1024, 4096, 0, 4096, 0);
        add_pair(512, 0, 1, 0, -1);
        add_pair(1536, -1, -1, -1, -1);
        add_pair(3000, 32'h80000000, 0, 32'h7fffffff, 0);
        add_random(140);
        drain();

        run_setting(0, 2, 1, 1, 140);
        run_setting(40960, 4096, 4096, 16384, 140);
        run_setting(65535, 8191, 8191, 32767, 140);
        run_setting(12345, 0, 0, 100, 120);
        run_setting(2048, 1, 3, 7, 120);
        run_setting(8192, 640, 480, 255, 120);
        run_setting(4096, 800, 600, 2048, 120);

        $display("%0d bin pairs sent over %0d register settings, %0d pixels checked",
                 pairs_sent, settings_run, pixels_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
